// ===== rtl/heap_sorter_core_defines.svh =====
// Assertion macros used by the checker file of the heap sorter.
`ifndef HEAP_SORTER_CORE_DEFINES_SVH
`define HEAP_SORTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap sorter check failed");

// The consequent must hold in the cycle after the antecedent.
`define HS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap sorter check failed");

`endif

// ===== rtl/hs_pkg.sv =====
package hs_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  // Child indexes reach 2 * (DEPTH - 1) + 1 before they are range checked.
  localparam int CHD_W     = IDX_W + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [CHD_W-1:0]            chd_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    word_t value;
    logic  end_run;
    logic  ovf;
  } res_t;

  // Index of the first child of a heap node.
  function automatic chd_t first_child(idx_t h);
    return chd_t'({h, 1'b1});
  endfunction

endpackage

// ===== rtl/hs_ram.sv =====
module hs_ram #(
  parameter int WORDS = 64,
  parameter int DW    = 32,
  localparam int AW   = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [WORDS];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hs_ctrl.sv =====
module hs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hs_pkg::word_t   in_value,
  input  logic            in_is_last,
  output hs_pkg::mem_req_t mem_req,
  input  hs_pkg::word_t   rd_data,
  output logic            res_valid,
  input  logic            res_ready,
  output hs_pkg::res_t    res
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_TOP,
    S_GET_TOP,
    S_GET_C1,
    S_GET_C2,
    S_CMP,
    S_PUT,
    S_X_RD0,
    S_X_RDI,
    S_X_SW,
    S_E_RD,
    S_E_CAP
  } state_t;

  state_t         state_r, state_nxt;
  hs_pkg::cnt_t   fill_r, fill_nxt;
  logic           ovf_r, ovf_nxt;
  hs_pkg::cnt_t   n_r, n_nxt;
  hs_pkg::cnt_t   i_r, i_nxt;
  logic           build_r, build_nxt;
  hs_pkg::idx_t   hole_r, hole_nxt;
  hs_pkg::idx_t   last_r, last_nxt;
  hs_pkg::idx_t   child_r, child_nxt;
  hs_pkg::idx_t   emit_r, emit_nxt;
  hs_pkg::word_t  held_r, held_nxt;
  hs_pkg::word_t  cval_r, cval_nxt;

  hs_pkg::cnt_t   n_new;
  hs_pkg::cnt_t   n_new_m1;
  hs_pkg::cnt_t   half_m1;
  hs_pkg::cnt_t   i_m1;
  hs_pkg::cnt_t   i_m2;
  hs_pkg::cnt_t   n_m1;
  hs_pkg::chd_t   c1_hole;
  hs_pkg::chd_t   c1_child;
  hs_pkg::chd_t   c2_child;
  hs_pkg::chd_t   last_ext;
  logic           emit_last;
  logic           sift_done;

  always_comb begin
    n_new    = (fill_r != hs_pkg::cnt_t'(hs_pkg::DEPTH)) ? fill_r + hs_pkg::cnt_t'(1) : fill_r;
    n_new_m1 = n_new - hs_pkg::cnt_t'(1);
    half_m1  = (n_new >> 1) - hs_pkg::cnt_t'(1);
    i_m1     = i_r - hs_pkg::cnt_t'(1);
    i_m2     = i_r - hs_pkg::cnt_t'(2);
    n_m1     = n_r - hs_pkg::cnt_t'(1);
    c1_hole  = hs_pkg::first_child(hole_r);
    c1_child = hs_pkg::first_child(child_r);
    c2_child = hs_pkg::chd_t'(child_r) + hs_pkg::chd_t'(1);
    last_ext = hs_pkg::chd_t'(last_r);
    emit_last = (hs_pkg::cnt_t'(emit_r) == n_m1);
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    build_nxt = build_r;
    hole_nxt  = hole_r;
    last_nxt  = last_r;
    child_nxt = child_r;
    emit_nxt  = emit_r;
    held_nxt  = held_r;
    cval_nxt  = cval_r;
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '{value: rd_data, end_run: emit_last, ovf: ovf_r};
    sift_done = 1'b0;

    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (fill_r != hs_pkg::cnt_t'(hs_pkg::DEPTH)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = fill_r[hs_pkg::IDX_W-1:0];
            mem_req.wdata = in_value;
            fill_nxt      = fill_r + hs_pkg::cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            n_nxt = n_new;
            if (n_new < hs_pkg::cnt_t'(2)) begin
              emit_nxt  = '0;
              state_nxt = S_E_RD;
            end else begin
              build_nxt = 1'b1;
              i_nxt     = n_new >> 1;
              hole_nxt  = half_m1[hs_pkg::IDX_W-1:0];
              last_nxt  = n_new_m1[hs_pkg::IDX_W-1:0];
              state_nxt = S_RD_TOP;
            end
          end
        end
      end
      S_RD_TOP: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = hole_r;
        state_nxt     = S_GET_TOP;
      end
      S_GET_TOP: begin
        held_nxt = rd_data;
        if (c1_hole <= last_ext) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = c1_hole[hs_pkg::IDX_W-1:0];
          child_nxt     = c1_hole[hs_pkg::IDX_W-1:0];
          state_nxt     = S_GET_C1;
        end else begin
          // A leaf already holds its own word.
          sift_done = 1'b1;
        end
      end
      S_GET_C1: begin
        cval_nxt = rd_data;
        if (c2_child <= last_ext) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = c2_child[hs_pkg::IDX_W-1:0];
          state_nxt     = S_GET_C2;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_GET_C2: begin
        if (cval_r < rd_data) begin
          cval_nxt  = rd_data;
          child_nxt = c2_child[hs_pkg::IDX_W-1:0];
        end
        state_nxt = S_CMP;
      end
      S_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hole_r;
        if (held_r < cval_r) begin
          // Move the larger child up and fetch the next level in the same cycle.
          mem_req.wdata = cval_r;
          hole_nxt      = child_r;
          if (c1_child <= last_ext) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = c1_child[hs_pkg::IDX_W-1:0];
            child_nxt     = c1_child[hs_pkg::IDX_W-1:0];
            state_nxt     = S_GET_C1;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          mem_req.wdata = held_r;
          sift_done     = 1'b1;
        end
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hole_r;
        mem_req.wdata = held_r;
        sift_done     = 1'b1;
      end
      S_X_RD0: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = '0;
        state_nxt     = S_X_RDI;
      end
      S_X_RDI: begin
        cval_nxt      = rd_data;
        mem_req.re    = 1'b1;
        mem_req.raddr = i_r[hs_pkg::IDX_W-1:0];
        state_nxt     = S_X_SW;
      end
      S_X_SW: begin
        // The old root goes to the end; the word from the end sifts down from the root.
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r[hs_pkg::IDX_W-1:0];
        mem_req.wdata = cval_r;
        held_nxt      = rd_data;
        hole_nxt      = '0;
        last_nxt      = i_m1[hs_pkg::IDX_W-1:0];
        if (i_r >= hs_pkg::cnt_t'(2)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = hs_pkg::idx_t'(1);
          child_nxt     = hs_pkg::idx_t'(1);
          state_nxt     = S_GET_C1;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_E_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = emit_r;
        state_nxt     = S_E_CAP;
      end
      S_E_CAP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (emit_last) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            emit_nxt  = emit_r + hs_pkg::idx_t'(1);
            state_nxt = S_E_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (sift_done) begin
      if (build_r) begin
        if (i_r == hs_pkg::cnt_t'(1)) begin
          build_nxt = 1'b0;
          i_nxt     = n_m1;
          state_nxt = S_X_RD0;
        end else begin
          i_nxt     = i_m1;
          hole_nxt  = i_m2[hs_pkg::IDX_W-1:0];
          state_nxt = S_RD_TOP;
        end
      end else begin
        if (i_r == hs_pkg::cnt_t'(1)) begin
          emit_nxt  = '0;
          state_nxt = S_E_RD;
        end else begin
          i_nxt     = i_m1;
          state_nxt = S_X_RD0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      build_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      build_r <= build_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    hole_r  <= hole_nxt;
    last_r  <= last_nxt;
    child_r <= child_nxt;
    emit_r  <= emit_nxt;
    held_r  <= held_nxt;
    cval_r  <= cval_nxt;
  end

endmodule

// ===== rtl/heap_sorter_core.sv =====
// Heapsort of one set of signed 32-bit words held in a 64-entry single-port-read RAM.
// Words are loaded one per cycle until a transfer with in_is_last; words past 64 are
// dropped and flagged on out_overflow for the whole run. The set is then sorted in
// place: heap build and extraction both sift down with one RAM read per cycle, moving
// the larger child up a level until the held word is no smaller or a leaf is reached.
// Results then leave in ascending order, one at a time, each read from the RAM before
// it is offered, the last marked with out_end_of_run. No input is taken from the last
// word of a set until the final result has been handed to the output register.
module heap_sorter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_value,
  input  logic                in_is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_sorted_value,
  output logic                out_end_of_run,
  output logic                out_overflow
);

  hs_pkg::mem_req_t mem_req;
  hs_pkg::word_t    rd_data;
  logic             res_valid;
  logic             res_ready;
  hs_pkg::res_t     res;

  logic             out_valid_r;
  hs_pkg::res_t     out_res_r;

  hs_ram #(
    .WORDS (hs_pkg::DEPTH),
    .DW    (hs_pkg::WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  hs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_is_last (in_is_last),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_res_r.value;
  assign out_end_of_run   = out_res_r.end_run;
  assign out_overflow     = out_res_r.ovf;

endmodule

// ===== rtl/heap_sorter_core_checker.sv =====
`include "heap_sorter_core_defines.svh"

module heap_sorter_core_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] in_value,
  input logic               in_is_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_sorted_value,
  input logic               out_end_of_run,
  input logic               out_overflow
);

  logic               run_r;
  logic signed [31:0] prev_r;
  logic               prev_ovf_r;
  logic               out_xfer;
  logic               in_xfer;

  assign out_xfer = out_valid && out_ready;
  assign in_xfer  = in_valid && in_ready;

  // The run is open once a result other than the final one has been transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (out_xfer) begin
      run_r <= !out_end_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      prev_r     <= out_sorted_value;
      prev_ovf_r <= out_overflow;
    end
  end

  `HS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sorted_value))
  `HS_ASSERT_NXT(a_last_stops_input, in_xfer && in_is_last, !in_ready)
  `HS_ASSERT_IMP(a_no_input_mid_run, run_r && !out_valid, !in_ready)
  `HS_ASSERT_IMP(a_ascending, run_r && out_valid, prev_r <= out_sorted_value)
  `HS_ASSERT_IMP(a_overflow_steady, run_r && out_valid, out_overflow == prev_ovf_r)

endmodule

bind heap_sorter_core heap_sorter_core_checker u_checker (.*);
